[design/mbsu_pkg.sv]
// Package for the multilevel bit sketch update unit.
// Holds default sizes, operation codes, sequencer states and control structs.
// No dependencies.
package mbsu_pkg;

    // Default sketch geometry
    localparam int ROWS_DEFAULT     = 4;
    localparam int COLS_DEFAULT     = 256;
    localparam int KEY_BITS_DEFAULT = 32;

    // Counter and field widths
    localparam int CNT_W  = 32;
    localparam int FUNC_W = 2;
    localparam int ROW_W  = 2;
    localparam int COL_W  = 8;
    localparam int KEY_W  = 32;
    localparam int SEL_W  = 6;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_FEED   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    // Control shared by all counter lanes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } lane_ctrl_t;

    // Control for the merging stage
    typedef struct packed {
        logic capture;
        logic in_range;
        logic is_update;
        logic is_read;
    } merge_ctrl_t;

endpackage

[design/multilevel_bit_sketch_update_unit.sv]
// Top level of the multilevel bit sketch update unit: sequencer, counter
// lanes and merging stage. Depends on mbsu_pkg, mbsu_lane, mbsu_merge.
//
// Channel   Direction  Handshake                 Fields
// command   in         start & !busy             func row column flow_key amount counter_sel
// result    out        done (one-cycle strobe)   count_value
//
// Each transaction steps through accept, memory read, and update and write.
// The result strobe falls in the cycle after the update, and a new transaction
// may be accepted in that same cycle. The read-modify-write of the lane
// memories sets this sequence. After reset a clearing pass zeroes the memories,
// one bucket a cycle, with busy high. The receiver cannot stall the result.
module multilevel_bit_sketch_update_unit #(
    parameter int ROWS     = mbsu_pkg::ROWS_DEFAULT,
    parameter int COLS     = mbsu_pkg::COLS_DEFAULT,
    parameter int KEY_BITS = mbsu_pkg::KEY_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [mbsu_pkg::FUNC_W-1:0]        func,
    input  logic [mbsu_pkg::ROW_W-1:0]         row,
    input  logic [mbsu_pkg::COL_W-1:0]         column,
    input  logic [mbsu_pkg::KEY_W-1:0]         flow_key,
    input  logic [mbsu_pkg::CNT_W-1:0]         amount,
    input  logic [mbsu_pkg::SEL_W-1:0]         counter_sel,
    output logic signed [mbsu_pkg::CNT_W-1:0]  count_value,
    output logic                               done
);

    localparam int SLOTS = KEY_BITS + 1;
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mbsu_pkg::state_t state_reg;
    mbsu_pkg::state_t state_next;

    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    logic [mbsu_pkg::FUNC_W-1:0] func_reg;
    logic [mbsu_pkg::ROW_W-1:0]  row_reg;
    logic [mbsu_pkg::COL_W-1:0]  column_reg;
    logic [mbsu_pkg::KEY_W-1:0]  key_reg;
    logic [mbsu_pkg::CNT_W-1:0]  amount_reg;
    logic [mbsu_pkg::SEL_W-1:0]  sel_reg;

    logic                        accept;
    logic                        in_range;
    logic                        is_update;
    logic                        is_read;
    logic [31:0]                 addr_wide;
    logic [AW-1:0]               bucket_addr;
    logic [AW-1:0]               lane_addr;
    logic [mbsu_pkg::CNT_W-1:0]  delta;
    mbsu_pkg::lane_ctrl_t        lane_ctrl;
    mbsu_pkg::merge_ctrl_t       merge_ctrl;
    logic [mbsu_pkg::CNT_W-1:0]  lane_data [SLOTS];

    assign accept = start && !busy;

    // Decode the held transaction
    assign in_range    = (32'(row_reg) < 32'(ROWS)) && (32'(column_reg) < 32'(COLS));
    assign is_update   = (func_reg == mbsu_pkg::FUNC_FEED) || (func_reg == mbsu_pkg::FUNC_REMOVE);
    assign is_read     = (func_reg == mbsu_pkg::FUNC_READ);
    assign addr_wide   = 32'(row_reg) * 32'(COLS) + 32'(column_reg);
    assign bucket_addr = addr_wide[AW-1:0];
    assign delta       = (func_reg == mbsu_pkg::FUNC_FEED) ? mbsu_pkg::CNT_W'(1)
                                                           : (mbsu_pkg::CNT_W'(0) - amount_reg);

    // Capture the command fields on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            row_reg    <= row;
            column_reg <= column;
            key_reg    <= flow_key;
            amount_reg <= amount;
            sel_reg    <= counter_sel;
        end
    end

    // Advance state and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mbsu_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            mbsu_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = mbsu_pkg::ST_IDLE;
                end
            end
            mbsu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mbsu_pkg::ST_READ;
                end
            end
            mbsu_pkg::ST_READ:
            begin
                state_next = mbsu_pkg::ST_UPDATE;
            end
            mbsu_pkg::ST_UPDATE:
            begin
                state_next = mbsu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mbsu_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        busy       = 1'b1;
        lane_ctrl  = '0;
        lane_addr  = bucket_addr;
        merge_ctrl = '0;
        case (state_reg)
            mbsu_pkg::ST_CLEAR:
            begin
                lane_ctrl.wr_en = 1'b1;
                lane_ctrl.clr   = 1'b1;
                lane_addr       = clr_cnt_reg;
            end
            mbsu_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            mbsu_pkg::ST_READ:
            begin
                lane_ctrl.rd_en = 1'b1;
            end
            mbsu_pkg::ST_UPDATE:
            begin
                lane_ctrl.wr_en      = in_range && is_update;
                merge_ctrl.capture   = 1'b1;
                merge_ctrl.in_range  = in_range;
                merge_ctrl.is_update = is_update;
                merge_ctrl.is_read   = is_read;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Counter lanes: lane 0 is the total, lane j follows key bit 32-j
    for (genvar j = 0; j < SLOTS; j++)
    begin : g_lane
        logic hit;
        if (j == 0)
        begin : g_total
            assign hit = 1'b1;
        end
        else
        begin : g_bit
            assign hit = key_reg[32 - j];
        end

        mbsu_lane #(
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .addr  (lane_addr),
            .hit   (hit),
            .delta (delta),
            .rdata (lane_data[j])
        );
    end

    // Merge lane results into the output
    mbsu_merge #(
        .SLOTS (SLOTS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (merge_ctrl),
        .lane_data   (lane_data),
        .delta       (delta),
        .sel         (sel_reg),
        .count_value (count_value),
        .done        (done)
    );

`ifndef ASSERT_OFF
    // An accepted transaction moves straight to the memory read
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == mbsu_pkg::ST_READ)
        else $error("accepted transaction did not start a read");

    // A read is always followed by the update
    a_read_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbsu_pkg::ST_READ |=> state_reg == mbsu_pkg::ST_UPDATE)
        else $error("read not followed by update");

    // Every update produces exactly one result strobe
    a_update_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbsu_pkg::ST_UPDATE |=> done)
        else $error("update did not produce a result");

    // A result strobe only follows an update
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == mbsu_pkg::ST_UPDATE)
        else $error("result strobe without an update");

    // The unit stays busy and gives no result strobe while the clearing pass runs
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mbsu_pkg::ST_CLEAR |-> busy && !done)
        else $error("activity during clearing pass");
`endif

endmodule

[design/mbsu_lane.sv]
// One counter lane: a memory holding one counter slot of every bucket,
// updated by read-modify-write. Depends on mbsu_pkg.
module mbsu_lane #(
    parameter int DEPTH = mbsu_pkg::ROWS_DEFAULT * mbsu_pkg::COLS_DEFAULT,
    parameter int AW    = $clog2(mbsu_pkg::ROWS_DEFAULT * mbsu_pkg::COLS_DEFAULT)
) (
    input  logic                        clk,
    input  mbsu_pkg::lane_ctrl_t        ctrl,
    input  logic [AW-1:0]               addr,
    input  logic                        hit,
    input  logic [mbsu_pkg::CNT_W-1:0]  delta,
    output logic [mbsu_pkg::CNT_W-1:0]  rdata
);

    logic [mbsu_pkg::CNT_W-1:0] mem [DEPTH];
    logic [mbsu_pkg::CNT_W-1:0] rdata_reg;
    logic [mbsu_pkg::CNT_W-1:0] wdata;

    // Form the new counter: zero on clear, add delta when this key bit is set
    always_comb
    begin
        if (ctrl.clr)
        begin
            wdata = '0;
        end
        else if (hit)
        begin
            wdata = rdata_reg + delta;
        end
        else
        begin
            wdata = rdata_reg;
        end
    end

    // Write and read the counter memory; read data is registered
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/mbsu_merge.sv]
// Merging stage: picks the updated bucket total, the selected lane counter or zero
// and holds it in the result register with its strobe. Depends on mbsu_pkg.
module mbsu_merge #(
    parameter int SLOTS = mbsu_pkg::KEY_BITS_DEFAULT + 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mbsu_pkg::merge_ctrl_t              ctrl,
    input  logic [mbsu_pkg::CNT_W-1:0]         lane_data [SLOTS],
    input  logic [mbsu_pkg::CNT_W-1:0]         delta,
    input  logic [mbsu_pkg::SEL_W-1:0]         sel,
    output logic signed [mbsu_pkg::CNT_W-1:0]  count_value,
    output logic                               done
);

    logic [mbsu_pkg::CNT_W-1:0] picked;
    logic [mbsu_pkg::CNT_W-1:0] result_next;
    logic [mbsu_pkg::CNT_W-1:0] result_reg;
    logic                       done_reg;

    // Select the read counter; a selector past the last lane gives zero
    always_comb
    begin
        picked = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (sel == mbsu_pkg::SEL_W'(j))
            begin
                picked = lane_data[j];
            end
        end
    end

    // Choose the result: updated total, read counter, or zero
    always_comb
    begin
        if (!ctrl.in_range)
        begin
            result_next = '0;
        end
        else if (ctrl.is_update)
        begin
            result_next = lane_data[0] + delta;
        end
        else if (ctrl.is_read)
        begin
            result_next = picked;
        end
        else
        begin
            result_next = '0;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            result_reg <= result_next;
        end
    end

    // Raise the strobe for one cycle after capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.capture;
        end
    end

    assign count_value = signed'(result_reg);
    assign done        = done_reg;

endmodule
